// ===== hdl/sefr_pkg.sv =====
// Package: shared types and constants of the STX/ETX frame receiver.
`default_nettype none
package sefr_pkg;

	// Result status codes
	localparam logic [1:0] ST_GOOD    = 2'd0;
	localparam logic [1:0] ST_BAD     = 2'd1;
	localparam logic [1:0] ST_OVER    = 2'd2;
	localparam logic [1:0] ST_TIMEOUT = 2'd3;

	// Input operation codes
	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;

	// Framing constants
	localparam logic [7:0] FR_STX          = 8'h02;
	localparam logic [7:0] FR_ETX          = 8'h03;
	localparam int         FR_OVERHEAD     = 5;
	localparam logic [7:0] FAULT_LIMIT_RST = 8'd20;

	// Controller to datapath commands
	typedef struct packed {
		logic take;     // input beat accepted this cycle
		logic rd_next;  // fetch the next stored frame byte
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic ev_good;    // accepted beat completes a good frame
		logic ev_result;  // accepted beat yields a single status result
		logic rd_last;    // frame byte on the output is the final one
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== hdl/sefr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module sefr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read, hold when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// ===== hdl/sefr_datapath.sv =====
// Datapath: frame assembly, checksum, timeout counter and result fields.
`default_nettype none
module sefr_datapath import sefr_pkg::*; #(
	parameter int MAX_FRAME = 32,
	localparam int AW = $clog2(MAX_FRAME)
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire dp_cmd_t    cmd,
	output dp_sts_t         sts,
	input  wire logic       operation,
	input  wire logic [7:0] rx_byte,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,
	output logic [1:0]      status,
	output logic [7:0]      frame_byte,
	output logic [4:0]      byte_index,
	output logic            last,
	output logic            link_ok
);

	logic [AW-1:0] fill_q;
	logic [AW-1:0] total_q;
	logic [7:0]    xor_q;
	logic [7:0]    len_hi_q;
	logic          etx_ok_q;
	logic [7:0]    tc_q;
	logic          fault_q;
	logic [7:0]    limit_q;
	logic [1:0]    out_status_q;
	logic [AW-1:0] rd_ptr_q;

	logic          is_byte;
	logic [AW-1:0] fill_inc;
	logic [16:0]   len_sum;
	logic          over;
	logic          body_done;
	logic          good;
	logic          bad;
	logic          store_wr;
	logic [7:0]    tc_base;
	logic [7:0]    tc_next;
	logic          rd_first;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    ram_data;

	// Classify the incoming beat against the frame state
	always_comb begin
		is_byte   = (operation == OP_BYTE);
		fill_inc  = fill_q + AW'(1);
		len_sum   = {1'b0, len_hi_q, rx_byte} + 17'(FR_OVERHEAD);
		over      = is_byte && (fill_q == AW'(2)) && (len_sum >= 17'(MAX_FRAME));
		body_done = is_byte && (fill_q >= AW'(3)) && (fill_inc == total_q);
		good      = body_done && (rx_byte == xor_q) && etx_ok_q;
		bad       = body_done && !good;
		store_wr  = cmd.take && is_byte && ((fill_q != '0) || (rx_byte == FR_STX));
	end

	// Timeout counter update: clamp above the limit, then saturating increment
	always_comb begin
		tc_base = (tc_q > limit_q) ? limit_q : tc_q;
		tc_next = (tc_base == 8'hFF) ? tc_base : tc_base + 8'd1;
	end

	assign sts.ev_good   = good;
	assign sts.ev_result = !is_byte || over || bad;
	assign sts.rd_last   = (rd_ptr_q == total_q - AW'(1));

	// Frame assembly and link state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			total_q      <= '0;
			xor_q        <= '0;
			len_hi_q     <= '0;
			etx_ok_q     <= 1'b0;
			tc_q         <= '0;
			fault_q      <= 1'b0;
			limit_q      <= FAULT_LIMIT_RST;
			out_status_q <= ST_GOOD;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (cmd.take) begin
				if (!is_byte) begin
					// Drop partial frame, update fault state
					fill_q       <= '0;
					tc_q         <= tc_next;
					fault_q      <= (tc_q > limit_q);
					out_status_q <= ST_TIMEOUT;
				end else if (fill_q == '0) begin
					// Hunt for STX
					if (rx_byte == FR_STX) begin
						fill_q <= AW'(1);
						xor_q  <= rx_byte;
					end
				end else if (fill_q == AW'(1)) begin
					len_hi_q <= rx_byte;
					xor_q    <= xor_q ^ rx_byte;
					fill_q   <= fill_inc;
				end else if (fill_q == AW'(2)) begin
					xor_q <= xor_q ^ rx_byte;
					if (over) begin
						fill_q       <= '0;
						out_status_q <= ST_OVER;
					end else begin
						fill_q  <= fill_inc;
						total_q <= len_sum[AW-1:0];
					end
				end else if (!body_done) begin
					// Body and ETX bytes
					xor_q  <= xor_q ^ rx_byte;
					fill_q <= fill_inc;
					if (fill_q == total_q - AW'(2)) begin
						etx_ok_q <= (rx_byte == FR_ETX);
					end
				end else begin
					// Checksum byte closes the frame
					fill_q <= '0;
					if (good) begin
						tc_q         <= '0;
						fault_q      <= 1'b0;
						out_status_q <= ST_GOOD;
					end else begin
						out_status_q <= ST_BAD;
					end
				end
			end
		end
	end

	// Read pointer for frame playback
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
		end else if (rd_first) begin
			rd_ptr_q <= '0;
		end else if (cmd.rd_next) begin
			rd_ptr_q <= rd_ptr_q + AW'(1);
		end
	end

	always_comb begin
		rd_first = cmd.take && good;
		rd_en    = rd_first || cmd.rd_next;
		rd_addr  = rd_first ? '0 : rd_ptr_q + AW'(1);
	end

	sefr_ram #(
		.WIDTH (8),
		.DEPTH (MAX_FRAME)
	) u_store (
		.clk     (clk),
		.wr_en   (store_wr),
		.wr_addr (fill_q),
		.wr_data (rx_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (ram_data)
	);

	// Result fields
	always_comb begin
		status     = out_status_q;
		frame_byte = (out_status_q == ST_GOOD) ? ram_data : 8'd0;
		byte_index = (out_status_q == ST_GOOD) ? 5'(rd_ptr_q) : 5'd0;
		last       = (out_status_q == ST_GOOD) ? sts.rd_last : 1'b1;
		link_ok    = !fault_q;
	end

endmodule
`default_nettype wire

// ===== hdl/sefr_ctrl.sv =====
// Controller: input acceptance and result sequencing state machine.
`default_nettype none
module sefr_ctrl import sefr_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	output logic         out_valid,
	input  wire logic    out_stall,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_RESULT = 2'd1;
	localparam logic [1:0] S_STREAM = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       out_beat;

	always_comb begin
		in_stall    = (state_q != S_IDLE);
		out_valid   = (state_q != S_IDLE);
		out_beat    = out_valid && !out_stall;
		cmd.take    = in_valid && !in_stall;
		cmd.rd_next = (state_q == S_STREAM) && out_beat && !sts.rd_last;
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.take && sts.ev_good) begin
					state_nxt = S_STREAM;
				end else if (cmd.take && sts.ev_result) begin
					state_nxt = S_RESULT;
				end
			end
			S_RESULT: begin
				if (out_beat) begin
					state_nxt = S_IDLE;
				end
			end
			S_STREAM: begin
				if (out_beat && sts.rd_last) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/stx_etx_xor_frame_receiver.sv =====
// Top level: STX/ETX length frame receiver with XOR checksum.
//
// Input channel (in_valid/in_stall): one beat is a received byte
// (operation 0) or a response-timeout event (operation 1). Output channel
// (out_valid/out_stall): one beat per result with status, frame_byte,
// byte_index, last and link_ok. fault_limit is written through
// cfg_wr_en/cfg_wr_data, which the user must do only while the block
// is idle; the block itself does not enforce this. A byte that yields
// no result leaves the block idle, so the next beat can follow at once.
// A beat that yields a result shows it on the output in the cycle after
// acceptance, and the next input beat can be taken in the cycle after
// that result beat is taken. A good frame of N bytes plays back from the
// frame store at one beat per cycle while out_stall is low; the store's
// single registered read port sets this rate. The input stalls from the
// cycle after the accepting beat until the last result beat is taken.
// out_stall freezes the result fields and the store read pointer.
// Reset clears the frame state, the timeout counter and the fault flag and
// loads fault_limit with 20; the frame store is not cleared.
`default_nettype none
module stx_etx_xor_frame_receiver import sefr_pkg::*; #(
	parameter int MAX_FRAME = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       operation,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      status,
	output logic [7:0]      frame_byte,
	output logic [4:0]      byte_index,
	output logic            last,
	output logic            link_ok,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	sefr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sefr_datapath #(
		.MAX_FRAME (MAX_FRAME)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.operation   (operation),
		.rx_byte     (rx_byte),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.status      (status),
		.frame_byte  (frame_byte),
		.byte_index  (byte_index),
		.last        (last),
		.link_ok     (link_ok)
	);

	// A timeout beat yields a timeout result in the next cycle
	a_timeout_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && operation == OP_TIMEOUT) |=>
		(out_valid && status == ST_TIMEOUT))
		else $error("timeout beat did not yield a timeout result");

	// Status results are single beats with cleared payload
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_GOOD) |-> (last && frame_byte == 8'd0 &&
		byte_index == 5'd0))
		else $error("status result not a single cleared beat");

	// Good frame bytes always report a healthy link
	a_good_link: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_GOOD) |-> link_ok)
		else $error("good frame byte with link fault");

	// Taking the last beat returns the block to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last) |=> (!out_valid && !in_stall))
		else $error("block not idle after last result beat");

endmodule
`default_nettype wire

// ===== tb/stx_etx_xor_frame_receiver_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the STX/ETX frame receiver with XOR checksum.
module stx_etx_xor_frame_receiver_tb;
	import sefr_pkg::*;

	localparam int MAX_FRAME      = 32;
	localparam int QUIET_LIMIT    = 4000;
	localparam int HOLD_OFF_TICKS = 300;
	localparam int SETTLE_TICKS   = 8;
	localparam int TAIL_TICKS     = 40;

	typedef struct packed {
		logic       op;
		logic [7:0] data;
	} rx_beat_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] frame_byte;
		logic [4:0] byte_index;
		logic       last;
		logic       link_ok;
	} rx_result_t;

	typedef enum {FLAW_NONE, FLAW_SUM, FLAW_ETX} frame_flaw_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       operation = OP_BYTE;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] status;
	logic [7:0] frame_byte;
	logic [4:0] byte_index;
	logic       last;
	logic       link_ok;
	logic       cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = 8'h00;

	rx_beat_t   beats_to_send[$];
	rx_result_t pending_results[$];
	int unsigned beats_queued = 0;
	int unsigned cycle_no = 0;
	int unsigned quiet_cycles = 0;
	int          fail_count = 0;
	bit          in_taken = 0;
	bit          out_taken = 0;
	bit          hold_req = 0;

	// Receiver state mirrored by the predictor
	logic [7:0]  frame_copy [MAX_FRAME];
	int          fill = 0;
	int          length_field = 0;
	logic [7:0]  xor_acc = 8'h00;
	logic [7:0]  timeout_tally = 8'h00;
	logic        link_fault = 1'b0;
	logic [7:0]  limit_copy = FAULT_LIMIT_RST;

	stx_etx_xor_frame_receiver #(
		.MAX_FRAME(MAX_FRAME)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.frame_byte(frame_byte),
		.byte_index(byte_index),
		.last(last),
		.link_ok(link_ok),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #2 clk = ~clk;

	// Stretches with no idling on either side
	function automatic bit smooth_stretch();
		return (cycle_no % 600) < 120;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (smooth_stretch() || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void post_result(input logic [1:0] st, input logic [7:0] b,
		input logic [4:0] idx, input logic fin);
		rx_result_t r;
		r.status = st;
		r.frame_byte = b;
		r.byte_index = idx;
		r.last = fin;
		r.link_ok = !link_fault;
		pending_results.push_back(r);
	endfunction

	function automatic void restart_hunt();
		fill = 0;
		length_field = 0;
		xor_acc = 8'h00;
	endfunction

	// Advance the mirrored receiver by one accepted beat and queue its results
	function automatic void predict_frame_results(input logic op, input logic [7:0] b);
		int total;
		if (op == OP_TIMEOUT) begin
			restart_hunt();
			if (timeout_tally > limit_copy) begin
				timeout_tally = limit_copy;
				link_fault = 1'b1;
			end else begin
				link_fault = 1'b0;
			end
			if (timeout_tally != 8'hFF)
				timeout_tally = timeout_tally + 8'd1;
			post_result(ST_TIMEOUT, 8'h00, 5'd0, 1'b1);
		end else if (fill == 0) begin
			// hunt for STX
			if (b == FR_STX) begin
				frame_copy[0] = b;
				xor_acc = b;
				fill = 1;
			end
		end else if (fill < 3) begin
			frame_copy[fill] = b;
			xor_acc ^= b;
			fill++;
			if (fill == 3) begin
				length_field = {frame_copy[1], frame_copy[2]};
				if (length_field + FR_OVERHEAD >= MAX_FRAME) begin
					restart_hunt();
					post_result(ST_OVER, 8'h00, 5'd0, 1'b1);
				end
			end
		end else begin
			total = length_field + FR_OVERHEAD;
			frame_copy[fill] = b;
			fill++;
			if (fill < total) begin
				xor_acc ^= b;
			end else if (b == xor_acc && frame_copy[total - 2] == FR_ETX) begin
				timeout_tally = 8'h00;
				link_fault = 1'b0;
				for (int i = 0; i < total; i++)
					post_result(ST_GOOD, frame_copy[i], 5'(i), i + 1 == total);
				restart_hunt();
			end else begin
				restart_hunt();
				post_result(ST_BAD, 8'h00, 5'd0, 1'b1);
			end
		end
	endfunction

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endtask

	// Sample both handshakes, predict, check and watch for a hang
	always @(posedge clk) begin
		rx_result_t want;
		if (arst_n) begin
			cycle_no++;
			in_taken = in_valid && !in_stall;
			out_taken = out_valid && !out_stall;
			if (cfg_wr_en)
				limit_copy = cfg_wr_data;
			if (in_taken)
				predict_frame_results(operation, rx_byte);
			if (out_taken) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result beat: status %0d, frame_byte %0d",
						status, frame_byte);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("status", want.status, status);
					check_field("frame_byte", want.frame_byte, frame_byte);
					check_field("byte_index", want.byte_index, byte_index);
					check_field("last", want.last, last);
					check_field("link_ok", want.link_ok, link_ok);
				end
			end
			if (in_taken || out_taken || cfg_wr_en)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Sender: hold a stalled beat, otherwise idle or present the next one
	int send_gap = 0;
	always @(negedge clk) begin
		rx_beat_t nxt;
		if (arst_n && !(in_valid && !in_taken)) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (beats_to_send.size() > 0) begin
				nxt = beats_to_send.pop_front();
				in_valid <= 1'b1;
				operation <= nxt.op;
				rx_byte <= nxt.data;
				send_gap = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls plus one long hold-off on request
	int stall_left = 0;
	int hold_left = 0;
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_req) begin
			hold_req = 0;
			hold_left = HOLD_OFF_TICKS - 1;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			stall_left = pick_gap();
			out_stall <= stall_left > 0;
			if (stall_left > 0)
				stall_left--;
		end
	end

	task automatic queue_beat(input logic op, input logic [7:0] b);
		rx_beat_t t;
		t.op = op;
		t.data = b;
		beats_to_send.push_back(t);
		beats_queued++;
	endtask

	task automatic queue_timeout();
		queue_beat(OP_TIMEOUT, 8'($urandom));
	endtask

	task automatic queue_header(input int body_len);
		logic [15:0] l;
		l = 16'(body_len);
		queue_beat(OP_BYTE, FR_STX);
		queue_beat(OP_BYTE, l[15:8]);
		queue_beat(OP_BYTE, l[7:0]);
	endtask

	// Build a full frame; a flaw breaks either the ETX or the checksum
	task automatic queue_frame(input int body_len, input frame_flaw_t flaw);
		logic [7:0]  sum;
		logic [7:0]  b;
		logic [15:0] l;
		l = 16'(body_len);
		queue_header(body_len);
		sum = FR_STX ^ l[15:8] ^ l[7:0];
		for (int i = 0; i < body_len; i++) begin
			b = 8'($urandom);
			queue_beat(OP_BYTE, b);
			sum ^= b;
		end
		b = FR_ETX;
		if (flaw == FLAW_ETX)
			b = FR_ETX ^ 8'($urandom_range(1, 255));
		queue_beat(OP_BYTE, b);
		sum ^= b;
		if (flaw == FLAW_SUM)
			sum ^= 8'($urandom_range(1, 255));
		queue_beat(OP_BYTE, sum);
	endtask

	function automatic int pick_body_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return MAX_FRAME - FR_OVERHEAD - 1;
		if (r < 20)
			return 0;
		if (r < 80)
			return $urandom_range(1, 8);
		return $urandom_range(9, MAX_FRAME - FR_OVERHEAD - 2);
	endfunction

	// Mostly well-formed frames, the rest broken frames, timeouts and noise
	task automatic queue_random_traffic(input int unsigned target);
		int unsigned start;
		int r;
		int n;
		start = beats_queued;
		while (beats_queued - start < target) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				queue_frame(pick_body_len(), FLAW_NONE);
			end else if (r < 63) begin
				queue_frame(pick_body_len(), FLAW_SUM);
			end else if (r < 70) begin
				queue_frame(pick_body_len(), FLAW_ETX);
			end else if (r < 76) begin
				queue_header($urandom_range(MAX_FRAME - FR_OVERHEAD, 65535));
			end else if (r < 84) begin
				// drop a partial frame with a timeout
				n = pick_body_len();
				queue_header(n);
				repeat ($urandom_range(0, n + 1))
					queue_beat(OP_BYTE, 8'($urandom));
				queue_timeout();
			end else if (r < 93) begin
				repeat ($urandom_range(1, 6))
					queue_timeout();
			end else begin
				repeat ($urandom_range(1, 4))
					queue_beat(OP_BYTE, 8'($urandom));
			end
		end
	endtask

	// Wait until every beat is sent and every result has come back
	task automatic wait_idle();
		do
			@(negedge clk);
		while (beats_to_send.size() != 0 || in_valid || pending_results.size() != 0);
	endtask

	task automatic write_fault_limit(input logic [7:0] value);
		wait_idle();
		repeat (SETTLE_TICKS) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= 8'($urandom);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: noise, smallest good frame, both frame errors,
		// oversize headers at the boundary and at the top, timeouts
		queue_beat(OP_BYTE, 8'h00);
		queue_beat(OP_BYTE, 8'hFF);
		queue_beat(OP_BYTE, FR_ETX);
		queue_frame(0, FLAW_NONE);
		queue_frame(1, FLAW_SUM);
		queue_frame(0, FLAW_ETX);
		queue_header(MAX_FRAME - FR_OVERHEAD);
		queue_header(65535);
		queue_header(4);
		queue_beat(OP_BYTE, 8'hAA);
		queue_timeout();
		queue_timeout();

		// Lowest limit: faults come quickly; hold off the output meanwhile
		write_fault_limit(8'd0);
		queue_random_traffic(55);
		hold_req = 1;

		// High limit: a run of timeouts, then a largest good frame
		write_fault_limit(8'd254);
		repeat (20)
			queue_timeout();
		queue_frame(MAX_FRAME - FR_OVERHEAD - 1, FLAW_NONE);
		queue_timeout();

		write_fault_limit(8'd3);
		queue_random_traffic(55);

		write_fault_limit(8'd1);
		queue_random_traffic(55);

		wait_idle();
		repeat (TAIL_TICKS) @(negedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/sefr_pkg.sv
hdl/sefr_ram.sv
hdl/sefr_datapath.sv
hdl/sefr_ctrl.sv
hdl/stx_etx_xor_frame_receiver.sv
tb/stx_etx_xor_frame_receiver_tb.sv
